FILE: rtl/core/ddo_pkg.sv
// Package for the odometry block: state type, fixed-point constants and CORDIC angle table.
// Used by differential_drive_odometry, its checker and its testbench; depends on nothing.
package ddo_pkg;

    localparam int CntW = 5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL1, ST_HSUM, ST_HWRAP, ST_ZRED,
        ST_CORD, ST_MUL2, ST_POS, ST_MAXS, ST_DONE
    } t_state;

    localparam logic [0:0] CFG_DIST = 1'b0;
    localparam logic [0:0] CFG_HEAD = 1'b1;

    localparam logic [23:0] DIST_SCALE_RST = 24'd41177;
    localparam logic [23:0] HEAD_SCALE_RST = 24'd74236;

    localparam logic signed [49:0] TWO_PI_Q16  = 50'sd411775;
    localparam logic signed [28:0] PI_Q24      = 29'sd52707179;
    localparam logic signed [28:0] TWO_PI_Q24  = 29'sd105414357;
    localparam logic signed [28:0] HALF_PI_Q24 = 29'sd26353589;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    function automatic logic signed [28:0] atan_q24(input logic [CntW-1:0] i);
        logic signed [28:0] v;
        unique case (i)
            5'd0:  v = 29'sd13176795;
            5'd1:  v = 29'sd7778716;
            5'd2:  v = 29'sd4110060;
            5'd3:  v = 29'sd2086331;
            5'd4:  v = 29'sd1047214;
            5'd5:  v = 29'sd524117;
            5'd6:  v = 29'sd262123;
            5'd7:  v = 29'sd131069;
            5'd8:  v = 29'sd65536;
            5'd9:  v = 29'sd32768;
            5'd10: v = 29'sd16384;
            5'd11: v = 29'sd8192;
            5'd12: v = 29'sd4096;
            5'd13: v = 29'sd2048;
            5'd14: v = 29'sd1024;
            5'd15: v = 29'sd512;
            5'd16: v = 29'sd256;
            5'd17: v = 29'sd128;
            5'd18: v = 29'sd64;
            5'd19: v = 29'sd32;
            5'd20: v = 29'sd16;
            5'd21: v = 29'sd8;
            5'd22: v = 29'sd4;
            5'd23: v = 29'sd2;
            default: v = 29'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/differential_drive_odometry.sv
// Differential-drive odometry built from two bit-serial multipliers and one CORDIC iteration
// per cycle. One request at a time; a new request is taken only after the last result has
// been loaded. The result register frees the input as soon as it is loaded. Synchronous
// active-low reset restores the default scales and clears position, heading and maxima.
module differential_drive_odometry
    import ddo_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // left_count[31:0], right_count[63:32]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata,   // x_pos, y_pos, heading_out, max_abs_x,
                                         // max_abs_y, max_abs_heading, zero pad
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_idx,
    input  logic [23:0]  i_cfg_data
);

    localparam logic [CntW-1:0] LastIter = CntW'(CORDIC_ITERATIONS - 1);

    t_state r_state, n_state;
    logic [CntW-1:0] r_cnt;

    logic [23:0] r_dscale, r_hscale, r_sc1, r_sc2;
    logic [31:0] r_prev_l, r_prev_r;
    logic signed [57:0] r_mc1, r_mc2, r_p1, r_p2;
    logic signed [31:0] r_dist_s;
    logic [31:0] r_dist;
    logic signed [49:0] r_h;
    logic signed [19:0] r_head;
    logic signed [28:0] r_z;
    logic r_flip;
    logic signed [33:0] r_cx, r_cy;
    logic signed [65:0] r_mx, r_my, r_px, r_py;
    logic signed [31:0] r_xacc, r_yacc;
    logic [30:0] r_maxx, r_maxy;
    logic [18:0] r_maxh;
    logic r_mvalid;
    logic [167:0] r_mdata;

    logic [31:0] w_dl, w_dr;
    logic signed [32:0] w_sum, w_dif;
    logic signed [57:0] w_r1, w_r2;
    logic signed [49:0] w_hw;
    logic signed [28:0] w_z0, w_z1;
    logic signed [33:0] w_xs, w_ys;
    logic signed [65:0] w_rx, w_ry;
    logic signed [36:0] w_nx, w_ny;
    logic [32:0] w_ax, w_ay;
    logic [19:0] w_ah;
    logic [30:0] w_sx, w_sy;
    logic [18:0] w_sh;

    always_comb begin
        w_dl  = s_axis_tdata[31:0] - r_prev_l;
        w_dr  = s_axis_tdata[63:32] - r_prev_r;
        w_sum = $signed({w_dl[31], w_dl}) + $signed({w_dr[31], w_dr});
        w_dif = $signed({w_dl[31], w_dl}) - $signed({w_dr[31], w_dr});
        w_r1  = (r_p1 + 58'sd128) >>> 8;
        w_r2  = (r_p2 + 58'sd128) >>> 8;
        if (r_h > TWO_PI_Q16) begin
            w_hw = r_h - TWO_PI_Q16;
        end else if (r_h < -TWO_PI_Q16) begin
            w_hw = r_h + TWO_PI_Q16;
        end else begin
            w_hw = r_h;
        end
        w_z0 = 29'(r_head) <<< 8;
        if (w_z0 > PI_Q24) begin
            w_z0 = w_z0 - TWO_PI_Q24;
        end else if (w_z0 < -PI_Q24) begin
            w_z0 = w_z0 + TWO_PI_Q24;
        end
        if (w_z0 > HALF_PI_Q24) begin
            w_z1 = w_z0 - PI_Q24;
        end else if (w_z0 < -HALF_PI_Q24) begin
            w_z1 = w_z0 + PI_Q24;
        end else begin
            w_z1 = w_z0;
        end
        w_xs = r_cx >>> r_cnt;
        w_ys = r_cy >>> r_cnt;
        w_rx = (r_px + 66'sd536870912) >>> 30;
        w_ry = (r_py + 66'sd536870912) >>> 30;
        w_nx = 37'(r_xacc) + w_rx[36:0];
        w_ny = 37'(r_yacc) + w_ry[36:0];
        w_ax = r_xacc[31] ? 33'(-34'(r_xacc)) : 33'(r_xacc);
        w_ay = r_yacc[31] ? 33'(-34'(r_yacc)) : 33'(r_yacc);
        w_ah = r_head[19] ? 20'(-21'(r_head)) : 20'(r_head);
        w_sx = w_ax[32:31] != 2'b00 ? 31'h7FFF_FFFF : w_ax[30:0];
        w_sy = w_ay[32:31] != 2'b00 ? 31'h7FFF_FFFF : w_ay[30:0];
        w_sh = w_ah[19] ? 19'h7FFFF : w_ah[18:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_MUL1;
            ST_MUL1:  if (r_cnt == 5'd23) n_state = ST_HSUM;
            ST_HSUM:  n_state = ST_HWRAP;
            ST_HWRAP: n_state = ST_ZRED;
            ST_ZRED:  n_state = ST_CORD;
            ST_CORD:  if (r_cnt == LastIter) n_state = ST_MUL2;
            ST_MUL2:  if (r_cnt == 5'd31) n_state = ST_POS;
            ST_POS:   n_state = ST_MAXS;
            ST_MAXS:  n_state = ST_DONE;
            ST_DONE:  if (!r_mvalid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = r_mvalid;
        m_axis_tdata  = r_mdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_dscale <= DIST_SCALE_RST;
            r_hscale <= HEAD_SCALE_RST;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_head   <= '0;
            r_xacc   <= '0;
            r_yacc   <= '0;
            r_maxx   <= '0;
            r_maxy   <= '0;
            r_maxh   <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DIST: r_dscale <= i_cfg_data;
                    CFG_HEAD: r_hscale <= i_cfg_data;
                    default:  r_dscale <= r_dscale;
                endcase
            end
            if (r_state == ST_DONE && (!r_mvalid || m_axis_tready)) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (s_axis_tvalid) begin
                        r_prev_l <= s_axis_tdata[31:0];
                        r_prev_r <= s_axis_tdata[63:32];
                        r_mc1 <= 58'(w_sum);
                        r_mc2 <= 58'(w_dif);
                        r_sc1 <= r_dscale;
                        r_sc2 <= r_hscale;
                        r_p1  <= '0;
                        r_p2  <= '0;
                    end
                end
                ST_MUL1: begin
                    if (r_sc1[0]) r_p1 <= r_p1 + r_mc1;
                    if (r_sc2[0]) r_p2 <= r_p2 + r_mc2;
                    r_mc1 <= r_mc1 <<< 1;
                    r_mc2 <= r_mc2 <<< 1;
                    r_sc1 <= r_sc1 >> 1;
                    r_sc2 <= r_sc2 >> 1;
                    r_cnt <= (r_cnt == 5'd23) ? '0 : r_cnt + 1'b1;
                end
                ST_HSUM: begin
                    if (w_r1 > 58'sd2147483647) begin
                        r_dist_s <= 32'sh7FFF_FFFF;
                    end else if (w_r1 < -58'sd2147483648) begin
                        r_dist_s <= 32'sh8000_0000;
                    end else begin
                        r_dist_s <= w_r1[31:0];
                    end
                    r_h <= 50'(r_head) + w_r2[49:0];
                end
                ST_HWRAP: begin
                    if (w_hw > 50'sd524287) begin
                        r_head <= 20'sh7FFFF;
                    end else if (w_hw < -50'sd524288) begin
                        r_head <= 20'sh80000;
                    end else begin
                        r_head <= w_hw[19:0];
                    end
                end
                ST_ZRED: begin
                    r_z    <= w_z1;
                    r_flip <= (w_z0 > HALF_PI_Q24) || (w_z0 < -HALF_PI_Q24);
                    r_cx   <= GAIN_Q30;
                    r_cy   <= '0;
                    r_cnt  <= '0;
                    r_dist <= r_dist_s;
                end
                ST_CORD: begin
                    if (r_z >= 0) begin
                        r_cx <= r_cx - w_ys;
                        r_cy <= r_cy + w_xs;
                        r_z  <= r_z - atan_q24(r_cnt);
                    end else begin
                        r_cx <= r_cx + w_ys;
                        r_cy <= r_cy - w_xs;
                        r_z  <= r_z + atan_q24(r_cnt);
                    end
                    if (r_cnt == LastIter) begin
                        r_cnt <= '0;
                        r_px  <= '0;
                        r_py  <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_MUL2: begin
                    if (r_cnt == 5'd0) begin
                        // first digit: take the rotated vector, sign-corrected
                        if (r_flip) begin
                            r_mx <= -(66'(r_cx) <<< 1);
                            r_my <= -(66'(r_cy) <<< 1);
                            if (r_dist[0]) begin
                                r_px <= -66'(r_cx);
                                r_py <= -66'(r_cy);
                            end
                        end else begin
                            r_mx <= 66'(r_cx) <<< 1;
                            r_my <= 66'(r_cy) <<< 1;
                            if (r_dist[0]) begin
                                r_px <= 66'(r_cx);
                                r_py <= 66'(r_cy);
                            end
                        end
                    end else begin
                        if (r_dist[0]) begin
                            if (r_cnt == 5'd31) begin
                                r_px <= r_px - r_mx;
                                r_py <= r_py - r_my;
                            end else begin
                                r_px <= r_px + r_mx;
                                r_py <= r_py + r_my;
                            end
                        end
                        r_mx <= r_mx <<< 1;
                        r_my <= r_my <<< 1;
                    end
                    r_dist <= r_dist >> 1;
                    r_cnt  <= (r_cnt == 5'd31) ? '0 : r_cnt + 1'b1;
                end
                ST_POS: begin
                    if (w_nx > 37'sd2147483647) r_xacc <= 32'sh7FFF_FFFF;
                    else if (w_nx < -37'sd2147483648) r_xacc <= 32'sh8000_0000;
                    else r_xacc <= w_nx[31:0];
                    if (w_ny > 37'sd2147483647) r_yacc <= 32'sh7FFF_FFFF;
                    else if (w_ny < -37'sd2147483648) r_yacc <= 32'sh8000_0000;
                    else r_yacc <= w_ny[31:0];
                end
                ST_MAXS: begin
                    if (w_sx > r_maxx) r_maxx <= w_sx;
                    if (w_sy > r_maxy) r_maxy <= w_sy;
                    if (w_sh > r_maxh) r_maxh <= w_sh;
                end
                ST_DONE: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_mdata  <= {3'b000, r_maxh, r_maxy, r_maxx, r_head, r_yacc, r_xacc};
                    end
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    a_max_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_maxx >= $past(r_maxx) && r_maxh >= $past(r_maxh))
        else $error("running maximum decreased");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == ST_IDLE))
        else $error("ready outside idle");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && n_state == ST_IDLE) |=> m_axis_tvalid)
        else $error("result not presented");

    a_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CORD) |-> (r_cnt <= LastIter))
        else $error("CORDIC counter out of range");

endmodule

FILE: tb/differential_drive_odometry_checker.sv
// Pose checker for the odometry block: tracks encoder requests, predicts the pose,
// heading and maxima, and compares each result field by field.
// Depends on ddo_pkg for the configuration indexes and the fixed-point constants.
module differential_drive_odometry_checker
    import ddo_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [63:0]  i_s_tdata,    // left_count[31:0], right_count[63:32]
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [167:0] i_m_tdata,    // x_pos, y_pos, heading_out, max_abs_x,
                                       // max_abs_y, max_abs_heading, zero pad
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_idx,
    input  logic [23:0]  i_cfg_data,
    output int           o_pending,
    output int           o_errors,
    output int           o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic signed [19:0] heading;
        logic [30:0]        max_x;
        logic [30:0]        max_y;
        logic [18:0]        max_heading;
    } t_pose;

    localparam longint ATAN_TBL [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    t_pose       expected_poses[$];
    logic [23:0] dist_scale;
    logic [23:0] head_scale;
    logic [31:0] last_left;
    logic [31:0] last_right;
    longint      heading_q16;
    longint      x_q16;
    longint      y_q16;
    longint      peak_x;
    longint      peak_y;
    longint      peak_heading;
    int          errors;
    int          results;

    assign o_pending = expected_poses.size();
    assign o_errors  = errors;
    assign o_results = results;

    function automatic longint round_off(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint abs_clamp(longint v, longint hi);
        longint a;
        a = (v < 0) ? -v : v;
        return (a > hi) ? hi : a;
    endfunction

    function automatic void rotate(input longint ang_q16, output longint c, output longint s);
        longint z, x, y, t, xs, ys;
        bit     flip;
        z = ang_q16 * 256;
        x = longint'(GAIN_Q30);
        y = 0;
        flip = 0;
        while (z > longint'(PI_Q24)) z -= longint'(TWO_PI_Q24);
        while (z < -longint'(PI_Q24)) z += longint'(TWO_PI_Q24);
        if (z > longint'(HALF_PI_Q24)) begin
            z -= longint'(PI_Q24);
            flip = 1;
        end else if (z < -longint'(HALF_PI_Q24)) begin
            z += longint'(PI_Q24);
            flip = 1;
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                t = x - ys;
                y = y + xs;
                z -= ATAN_TBL[i];
            end else begin
                t = x + ys;
                y = y - xs;
                z += ATAN_TBL[i];
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic t_pose predict_pose(logic [31:0] left, logic [31:0] right);
        logic signed [31:0] dl32, dr32;
        longint dl, dr, step, h, c, s;
        t_pose  p;
        dl32 = left - last_left;
        dr32 = right - last_right;
        dl = dl32;
        dr = dr32;
        last_left = left;
        last_right = right;
        step = clamp(round_off((dl + dr) * longint'(dist_scale), 8),
                     -64'sd2147483648, 64'sd2147483647);
        h = heading_q16 + round_off((dl - dr) * longint'(head_scale), 8);
        if (h > longint'(TWO_PI_Q16)) h -= longint'(TWO_PI_Q16);
        else if (h < -longint'(TWO_PI_Q16)) h += longint'(TWO_PI_Q16);
        heading_q16 = clamp(h, -524288, 524287);
        rotate(heading_q16, c, s);
        x_q16 = clamp(x_q16 + round_off(step * c, 30), -64'sd2147483648, 64'sd2147483647);
        y_q16 = clamp(y_q16 + round_off(step * s, 30), -64'sd2147483648, 64'sd2147483647);
        if (abs_clamp(x_q16, 2147483647) > peak_x) peak_x = abs_clamp(x_q16, 2147483647);
        if (abs_clamp(y_q16, 2147483647) > peak_y) peak_y = abs_clamp(y_q16, 2147483647);
        if (abs_clamp(heading_q16, 524287) > peak_heading)
            peak_heading = abs_clamp(heading_q16, 524287);
        p.x_pos = x_q16[31:0];
        p.y_pos = y_q16[31:0];
        p.heading = heading_q16[19:0];
        p.max_x = peak_x[30:0];
        p.max_y = peak_y[30:0];
        p.max_heading = peak_heading[18:0];
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    initial begin
        errors = 0;
        results = 0;
    end

    always @(posedge i_clk) begin
        t_pose want;
        t_pose got;
        if (!i_rst_n) begin
            expected_poses.delete();
            dist_scale <= DIST_SCALE_RST;
            head_scale <= HEAD_SCALE_RST;
            last_left = '0;
            last_right = '0;
            heading_q16 = 0;
            x_q16 = 0;
            y_q16 = 0;
            peak_x = 0;
            peak_y = 0;
            peak_heading = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DIST) dist_scale <= i_cfg_data;
                else if (i_cfg_idx == CFG_HEAD) head_scale <= i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready)
                expected_poses.push_back(predict_pose(i_s_tdata[31:0], i_s_tdata[63:32]));
            if (i_m_tvalid && i_m_tready) begin
                results++;
                got.x_pos = i_m_tdata[31:0];
                got.y_pos = i_m_tdata[63:32];
                got.heading = i_m_tdata[83:64];
                got.max_x = i_m_tdata[114:84];
                got.max_y = i_m_tdata[145:115];
                got.max_heading = i_m_tdata[164:146];
                if (expected_poses.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_poses.pop_front();
                    if (got.x_pos !== want.x_pos)
                        report_mismatch("x_pos", got.x_pos, want.x_pos);
                    if (got.y_pos !== want.y_pos)
                        report_mismatch("y_pos", got.y_pos, want.y_pos);
                    if (got.heading !== want.heading)
                        report_mismatch("heading_out", got.heading, want.heading);
                    if (got.max_x !== want.max_x)
                        report_mismatch("max_abs_x", got.max_x, want.max_x);
                    if (got.max_y !== want.max_y)
                        report_mismatch("max_abs_y", got.max_y, want.max_y);
                    if (got.max_heading !== want.max_heading)
                        report_mismatch("max_abs_heading", got.max_heading, want.max_heading);
                end
            end
        end
    end
endmodule

FILE: tb/differential_drive_odometry_tb.sv
// Top of the odometry testbench: clock, reset, encoder requests, scale writes and
// receiver back-pressure. Depends on ddo_pkg, differential_drive_odometry and
// differential_drive_odometry_checker.
module differential_drive_odometry_tb
    import ddo_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 24 + 16 + 39;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [167:0] m_axis_tdata;
    logic         i_cfg_we;
    logic [0:0]   i_cfg_idx;
    logic [23:0]  i_cfg_data;

    int           pending;
    int           errors;
    int           results;
    int           send_idle_pct;
    int           recv_stall_pct;
    logic         hold_req;
    int           hold_cnt;
    logic [31:0]  left_now;
    logic [31:0]  right_now;
    int           sent;

    differential_drive_odometry i_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    differential_drive_odometry_checker i_chk (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_pending(pending), .o_errors(errors), .o_results(results)
    );

    initial i_clk = 0;
    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    initial begin
        hold_cnt = 0;
        m_axis_tready = 0;
    end

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_cnt <= 400;
            m_axis_tready <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    task automatic send_counts(logic [31:0] left, logic [31:0] right);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {right, left};
        left_now = left;
        right_now = right;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_scales(logic [23:0] dscale, logic [23:0] head);
        i_cfg_we <= 1;
        i_cfg_idx <= CFG_DIST;
        i_cfg_data <= dscale;
        @(posedge i_clk);
        i_cfg_idx <= CFG_HEAD;
        i_cfg_data <= head;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic directed_moves();
        send_counts(32'd0, 32'd0);
        send_counts(32'd100, 32'd100);
        send_counts(32'd1100, -32'sd900);
        send_counts(32'd500, 32'd2000);
        send_counts(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_counts(32'h8000_0000, 32'h8000_0000);
        send_counts(32'h7FFF_FFFF, 32'h8000_0000);
        send_counts(32'hFFFF_FFFF, 32'h0000_0000);
        send_counts(32'h8000_0000, 32'h7FFF_FFFF);
        send_counts(32'h0000_0000, 32'hFFFF_FFFF);
        send_counts(32'h5555_5555, 32'hAAAA_AAAA);
        send_counts(32'hAAAA_AAAA, 32'h5555_5555);
        send_counts(32'h2AAA_AAAA, 32'h2AAA_AAAA);
        send_counts(32'h5555_5554, 32'h5555_5554);
        send_counts(32'h7FFF_FFF0, 32'h7FFF_FFF0);
        send_counts(32'h0000_1000, 32'h0000_1000);
        send_counts(32'h0000_1000, 32'h0000_1000);
    endtask

    task automatic random_moves(int n);
        logic [31:0] l, r;
        repeat (n) begin
            if ($urandom_range(99) < 80) begin
                l = left_now + 32'($urandom_range(0, 4000)) - 32'd2000;
                r = right_now + 32'($urandom_range(0, 4000)) - 32'd2000;
            end else begin
                l = $urandom;
                r = $urandom;
            end
            send_counts(l, r);
        end
    endtask

    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_DIST;
        i_cfg_data = '0;
        hold_req = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        left_now = '0;
        right_now = '0;
        sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        directed_moves();
        drain();
        write_scales(24'hFF_FFFF, 24'hFF_FFFF);
        directed_moves();
        drain();

        write_scales(24'd0, 24'd0);
        random_moves(20);
        drain();

        write_scales(24'd41177, 24'd74236);
        random_moves(90);
        drain();
        send_idle_pct = 57;
        write_scales(24'($urandom), 24'($urandom_range(0, 2000000)));
        random_moves(90);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 57;
        write_scales(24'($urandom_range(0, 300000)), 24'($urandom));
        random_moves(90);
        hold_req <= 1;
        @(posedge i_clk);
        hold_req <= 0;
        random_moves(10);
        drain();

        send_idle_pct = 16;
        recv_stall_pct = 16;
        write_scales(24'($urandom), 24'($urandom));
        random_moves(90);
        drain();

        $display("Sent %0d encoder requests over six scale settings, %0d results checked,",
                 sent, results);
        $display("with directed wrap and saturation cases and four idle/stall mixes.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/ddo_pkg.sv
rtl/core/differential_drive_odometry.sv
tb/differential_drive_odometry_checker.sv
tb/differential_drive_odometry_tb.sv
